@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked, reset-qualified property checks; define ASSERT_OFF to drop them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Immediate-style check sampled on every rising edge out of reset.
`define DQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Implication check: antecedent, then consequent in the following cycle.
`define DQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DQ_ASSERT(lbl, prop, msg)
`define DQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ hdl/dq_pkg.sv @@
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types and codes of the double-ended queue.
// ----------------------------------------------------------------------------
`default_nettype none
package dq_pkg;

  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_BACK   = 2'd3
  } dq_op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } dq_status_t;

  // Command with at most one bit set, broadcast to every cell; already gated by full/empty.
  typedef struct packed {
    logic push_front;
    logic push_back;
    logic pop_front;
    logic pop_back;
  } dq_cmd_t;

endpackage
`default_nettype wire

@@ hdl/dq_cell.sv @@
// ----------------------------------------------------------------------------
// dq_cell
// One storage cell of the shifting deque: holds a word and its valid bit.
// ----------------------------------------------------------------------------
`default_nettype none
module dq_cell
  import dq_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire dq_cmd_t               cmd,
  input  wire logic [DATA_WIDTH-1:0] push_value,
  input  wire logic [DATA_WIDTH-1:0] left_data,
  input  wire logic                  left_vld,
  input  wire logic [DATA_WIDTH-1:0] right_data,
  input  wire logic                  right_vld,
  output logic      [DATA_WIDTH-1:0] data,
  output logic                       vld,
  output logic      [DATA_WIDTH-1:0] back_tap
);

  logic [DATA_WIDTH-1:0] data_r, data_nxt;
  logic                  vld_r, vld_nxt;
  logic                  is_last;

  // Last occupied cell: valid with an empty neighbour towards the back.
  assign is_last = vld_r && !right_vld;

  always_comb begin
    data_nxt = data_r;
    vld_nxt  = vld_r;
    priority if (cmd.push_front) begin
      data_nxt = left_data;
      vld_nxt  = left_vld;
    end else if (cmd.pop_front) begin
      data_nxt = right_data;
      vld_nxt  = right_vld;
    end else if (cmd.push_back) begin
      if (!vld_r && left_vld) begin
        data_nxt = push_value;
        vld_nxt  = 1'b1;
      end
    end else if (cmd.pop_back) begin
      if (is_last) vld_nxt = 1'b0;
    end else begin
      // no command: hold
      data_nxt = data_r;
      vld_nxt  = vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data     = data_r;
  assign vld      = vld_r;
  assign back_tap = is_last ? data_r : '0;

endmodule
`default_nettype wire

@@ hdl/double_ended_queue.sv @@
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque built as a row of shifting cells; the front sits in cell 0.
// ----------------------------------------------------------------------------
// The result beat appears in the cycle after the command is taken.
// Throughput: one command per cycle, busy never rises; each beat touches only
//   the cells' neighbour moves and the occupancy counter.
// Reset: synchronous, clears the occupancy counter, the result valid and every
//   cell valid bit; cell data is left as is. The receiver cannot stall the result strobe.
`default_nettype none
`include "assert_macros.svh"
module double_ended_queue
  import dq_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [1:0]                    in_op,
  input  wire logic [DATA_WIDTH-1:0]         in_push_value,
  output logic                               out_valid,
  output logic      [DATA_WIDTH-1:0]         out_popped_value,
  output logic      [DATA_WIDTH-1:0]         out_front_value,
  output logic      [DATA_WIDTH-1:0]         out_back_value,
  output logic      [$clog2(DEPTH+1)-1:0]    out_occupancy,
  output logic                               out_is_empty,
  output logic      [1:0]                    out_status
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DEPTH);

  // Occupancy counter and result registers
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  valid_r;
  logic [DATA_WIDTH-1:0] popped_r, popped_nxt;
  dq_status_t            status_r, status_nxt;

  logic    accept;
  logic    full, empty;
  dq_cmd_t cmd;
  dq_op_t  op;

  // Cell row: element k from the front lives in cell k.
  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic                  cell_vld  [DEPTH];
  logic [DATA_WIDTH-1:0] cell_tap  [DEPTH];
  logic [DATA_WIDTH-1:0] back_word;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign op     = dq_op_t'(in_op);
  assign full   = (cnt_r == CNT_MAX);
  assign empty  = (cnt_r == '0);

  // Only the single last-occupied cell drives a non-zero tap; OR them together.
  always_comb begin
    back_word = '0;
    for (int k = 0; k < DEPTH; k++) begin
      back_word = back_word | cell_tap[k];
    end
  end

  // Decode the beat into a gated cell command, counter move and result.
  always_comb begin
    cmd        = '0;
    cnt_nxt    = cnt_r;
    popped_nxt = '0;
    status_nxt = ST_OK;
    if (accept) begin
      unique case (op)
        OP_PUSH_FRONT, OP_PUSH_BACK: begin
          if (full) begin
            status_nxt = ST_FULL;
          end else begin
            cmd.push_front = (op == OP_PUSH_FRONT);
            cmd.push_back  = (op == OP_PUSH_BACK);
            cnt_nxt        = cnt_r + 1'b1;
          end
        end
        OP_POP_FRONT: begin
          if (empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            cmd.pop_front = 1'b1;
            popped_nxt    = cell_data[0];
            cnt_nxt       = cnt_r - 1'b1;
          end
        end
        OP_POP_BACK: begin
          if (empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            cmd.pop_back = 1'b1;
            popped_nxt   = back_word;
            cnt_nxt      = cnt_r - 1'b1;
          end
        end
        default: begin
          status_nxt = ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      cnt_r   <= cnt_nxt;
      valid_r <= accept;
    end
  end

  // Result payload: loaded on every beat taken, no reset needed.
  always_ff @(posedge clk) begin
    if (accept) begin
      popped_r <= popped_nxt;
      status_r <= status_nxt;
    end
  end

  // Cell row; the head sees the push value as an always-valid left neighbour, the tail an empty right one.
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [DATA_WIDTH-1:0] l_data, r_data;
    logic                  l_vld, r_vld;

    if (k == 0) begin : g_head
      assign l_data = in_push_value;
      assign l_vld  = 1'b1;
    end else begin : g_mid_l
      assign l_data = cell_data[k-1];
      assign l_vld  = cell_vld[k-1];
    end

    if (k == DEPTH - 1) begin : g_tail
      assign r_data = '0;
      assign r_vld  = 1'b0;
    end else begin : g_mid_r
      assign r_data = cell_data[k+1];
      assign r_vld  = cell_vld[k+1];
    end

    dq_cell #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .push_value (in_push_value),
      .left_data  (l_data),
      .left_vld   (l_vld),
      .right_data (r_data),
      .right_vld  (r_vld),
      .data       (cell_data[k]),
      .vld        (cell_vld[k]),
      .back_tap   (cell_tap[k])
    );
  end

  // Result beat: front/back read straight from the settled cell row.
  assign out_valid        = valid_r;
  assign out_popped_value = popped_r;
  assign out_front_value  = cell_vld[0] ? cell_data[0] : '0;
  assign out_back_value   = back_word;
  assign out_occupancy    = cnt_r;
  assign out_is_empty     = (cnt_r == '0);
  assign out_status       = status_r;

  // Checks
  `DQ_ASSERT_NEXT(a_beat_follows, accept, out_valid, "result beat missing after command")
  `DQ_ASSERT(a_cnt_bound, cnt_r <= CNT_MAX, "occupancy above depth")
  `DQ_ASSERT(a_head_vld, (cnt_r != '0) == cell_vld[0], "front cell valid disagrees with count")
  `DQ_ASSERT(a_empty_zero, !out_is_empty || (out_front_value == '0 && out_back_value == '0),
             "empty queue shows non-zero ends")

endmodule
`default_nettype wire
